[rtl/core/utfe_pkg.sv]
// Shared types, constants and byte-forming helpers for the UTF-16 to UTF-8 encoder.
package utfe_pkg;

  typedef logic [20:0] cp_t;
  typedef logic [1:0]  err_t;
  typedef logic [1:0]  bidx_t;

  // Error codes carried on the result channel
  localparam err_t ERR_NONE          = 2'd0;
  localparam err_t ERR_HIGH_AT_END   = 2'd1;
  localparam err_t ERR_UNPAIRED_HIGH = 2'd2;
  localparam err_t ERR_LONE_LOW      = 2'd3;

  // Surrogate ranges
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  // Code point bounds
  localparam cp_t SUPP_BASE = 21'h01_0000;
  localparam cp_t MAX_1B    = 21'h00_007F;
  localparam cp_t MAX_2B    = 21'h00_07FF;
  localparam cp_t MAX_3B    = 21'h00_FFFF;

  // UTF-8 byte marks
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] LEAD_4B   = 8'hF0;
  localparam logic [7:0] CONT_MARK = 8'h80;

  // One queued job: a code point to encode, or an error report
  typedef struct packed {
    cp_t   cp;
    err_t  err;
    bidx_t last_idx;   // index of the final byte (0..3)
  } job_t;

  // Index of the last UTF-8 byte for a code point
  function automatic bidx_t utf8_last_idx(cp_t cp);
    bidx_t n;
    if (cp <= MAX_1B)      n = 2'd0;
    else if (cp <= MAX_2B) n = 2'd1;
    else if (cp <= MAX_3B) n = 2'd2;
    else                   n = 2'd3;
    return n;
  endfunction

  // Byte number idx of the UTF-8 sequence for cp
  function automatic logic [7:0] utf8_byte(cp_t cp, bidx_t last_idx, bidx_t idx);
    bidx_t      sh;
    logic [5:0] six;
    logic [7:0] b;
    sh = last_idx - idx;
    case (sh)
      2'd0:    six = cp[5:0];
      2'd1:    six = cp[11:6];
      2'd2:    six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      case (last_idx)
        2'd0:    b = cp[7:0];
        2'd1:    b = LEAD_2B | {2'b00, six};
        2'd2:    b = LEAD_3B | {2'b00, six};
        default: b = LEAD_4B | {2'b00, six};
      endcase
    end else begin
      b = CONT_MARK | {2'b00, six};
    end
    return b;
  endfunction

endpackage

[rtl/core/utfe_if.sv]
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
interface utfe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink   (input valid, input code_unit, input string_end, output ready);
endinterface

interface utfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output error_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input error_code, input last_of_run,
                  output ready);
endinterface

[rtl/core/utfe_front.sv]
// Front end: accepts code units, pairs surrogates, tracks abort state, queues jobs.
module utfe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  utfe_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output utfe_pkg::job_t  q_job
);

  logic       ignore_invalid_r;
  logic [9:0] high_payload_r, high_payload_nxt;
  logic       high_pending_r, high_pending_nxt;
  logic       discarding_r, discarding_nxt;

  logic            xfer;
  logic            is_high, is_low, strict, have;
  utfe_pkg::err_t  err;
  utfe_pkg::cp_t   cp;

  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign strict      = !ignore_invalid_r;
  assign is_high     = in_ch.code_unit inside {[utfe_pkg::HIGH_FIRST:utfe_pkg::HIGH_LAST]};
  assign is_low      = in_ch.code_unit inside {[utfe_pkg::LOW_FIRST:utfe_pkg::LOW_LAST]};

  // Classify the unit and compute next surrogate / abort state
  always_comb begin
    high_payload_nxt = high_payload_r;
    high_pending_nxt = high_pending_r;
    discarding_nxt   = discarding_r;
    err              = utfe_pkg::ERR_NONE;
    cp               = '0;
    have             = 1'b0;
    q_push           = 1'b0;

    if (xfer) begin
      if (discarding_r) begin
        if (in_ch.string_end) discarding_nxt = 1'b0;
      end else begin
        // held high surrogate meets the next unit
        if (high_pending_r) begin
          high_pending_nxt = 1'b0;
          if (is_low) begin
            cp   = utfe_pkg::SUPP_BASE + {1'b0, high_payload_r, in_ch.code_unit[9:0]};
            have = 1'b1;
          end else if (strict) begin
            err = utfe_pkg::ERR_UNPAIRED_HIGH;
          end
        end

        if (!have && err == utfe_pkg::ERR_NONE) begin
          if (is_high) begin
            if (in_ch.string_end) begin
              if (strict) err = utfe_pkg::ERR_HIGH_AT_END;
            end else begin
              high_pending_nxt = 1'b1;
              high_payload_nxt = in_ch.code_unit[9:0];
            end
          end else if (is_low) begin
            if (strict) err = utfe_pkg::ERR_LONE_LOW;
          end else begin
            cp   = {5'd0, in_ch.code_unit};
            have = 1'b1;
          end
        end

        if (err != utfe_pkg::ERR_NONE) begin
          q_push           = 1'b1;
          high_pending_nxt = 1'b0;
          if (!in_ch.string_end) discarding_nxt = 1'b1;
        end else begin
          q_push = have;
          if (in_ch.string_end) high_pending_nxt = 1'b0;
        end
      end
    end
  end

  // Job payload: error jobs carry one zero byte
  always_comb begin
    q_job.err = err;
    if (err != utfe_pkg::ERR_NONE) begin
      q_job.cp       = '0;
      q_job.last_idx = 2'd0;
    end else begin
      q_job.cp       = cp;
      q_job.last_idx = utfe_pkg::utf8_last_idx(cp);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_invalid_r <= 1'b0;
      high_payload_r   <= '0;
      high_pending_r   <= 1'b0;
      discarding_r     <= 1'b0;
    end else begin
      if (cfg_we) ignore_invalid_r <= cfg_wdata;
      high_payload_r <= high_payload_nxt;
      high_pending_r <= high_pending_nxt;
      discarding_r   <= discarding_nxt;
    end
  end

endmodule

[rtl/core/utfe_queue.sv]
// Small job queue between front and back ends.
module utfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utfe_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output utfe_pkg::job_t  pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utfe_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_job   = mem[rd_ptr_r];

  // Storage write
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

[rtl/core/utfe_back.sv]
// Back end: expands each queued job into UTF-8 bytes, one transfer per byte.
module utfe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  utfe_pkg::job_t  q_job,
  output logic            q_pop,
  utfe_out_if.source      out_ch
);

  logic                   cur_valid_r;
  utfe_pkg::job_t         cur_r;
  utfe_pkg::bidx_t        idx_r;
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  utfe_pkg::err_t         out_err_r;
  logic                   out_last_r;

  logic                   out_free, out_load, cur_last;
  logic [7:0]             next_byte;

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = cur_valid_r && out_free;
  assign cur_last = (idx_r == cur_r.last_idx);
  assign q_pop    = q_valid && (!cur_valid_r || (out_load && cur_last));

  assign next_byte = (cur_r.err != utfe_pkg::ERR_NONE) ? 8'h00 :
                     utfe_pkg::utf8_byte(cur_r.cp, cur_r.last_idx, idx_r);

  // Current job and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (out_load && cur_last) begin
      cur_valid_r <= 1'b0;
    end else if (out_load) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= next_byte;
      out_err_r  <= cur_r.err;
      out_last_r <= cur_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.error_code  = out_err_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

[rtl/core/utf16_to_utf8_encoder.sv]
// UTF-16 to UTF-8 encoder top level: front end, job queue and byte emitter.
//
// Usage:
//   in_ch  carries one UTF-16 code unit per transfer, with string_end on the
//          last unit of a string. out_ch carries one UTF-8 byte per transfer;
//          last_of_run marks the final byte caused by one input unit, and
//          error_code is nonzero (with a zero byte) on an error report.
//   cfg_we/cfg_wdata write ignore_invalid (reset 0 = strict). Write it only
//   while the block is idle.
// Timing:
//   The first byte of a unit passes through the job queue, the current-job
//   register and the output register before out_ch offers it. The byte
//   emitter sends one byte per cycle while out_ch.ready is high: one unit
//   per cycle for ASCII, four bytes for a supplementary code point. A held
//   high surrogate or a discarded unit queues no job. The job queue
//   (QUEUE_DEPTH entries) lets input keep flowing meanwhile.
// Reset and stalls:
//   Synchronous active-low reset empties the queue and output register and
//   clears held surrogate and abort state. When out_ch.ready is low the
//   output byte holds; the queue fills and in_ch.ready then drops.
module utf16_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  utfe_in_if.sink     in_ch,
  utfe_out_if.source  out_ch
);

  logic            q_push, q_full, q_pop, q_valid;
  utfe_pkg::job_t  push_job, pop_job;

  utfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  utfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  utfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
